@@ hdl/multitouch_event_decoder_top_assert.svh @@
// Assertion macros shared by the multitouch event decoder modules.
// Included by files that carry concurrent checks.
`ifndef MULTITOUCH_EVENT_DECODER_TOP_ASSERT_SVH
`define MULTITOUCH_EVENT_DECODER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/mtd_pkg.sv @@
// Package for the multitouch event decoder: event codes, types, queue entry.
// No dependencies.
`timescale 1ns / 1ps
package mtd_pkg;
    localparam logic [15:0] EVT_SYNC     = 16'd0;
    localparam logic [15:0] EVT_ABS      = 16'd3;
    localparam logic [15:0] AXIS_SLOT    = 16'h2f;
    localparam logic [15:0] AXIS_TRACK   = 16'h39;
    localparam logic [15:0] AXIS_X       = 16'h35;
    localparam logic [15:0] AXIS_Y       = 16'h36;
    localparam logic [15:0] SYNC_FULL    = 16'd0;
    localparam logic [15:0] SYNC_CONTACT = 16'd2;

    localparam logic [1:0] REG_XMIN = 2'd0;
    localparam logic [1:0] REG_XMAX = 2'd1;
    localparam logic [1:0] REG_YMIN = 2'd2;
    localparam logic [1:0] REG_YMAX = 2'd3;

    // classified operation passed from front to back
    typedef enum logic [2:0] {
        OP_SLOT, OP_TRACK, OP_X, OP_Y, OP_CONTACT, OP_FULL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DIV, ST_OUT, ST_EMPTY
    } t_state;
endpackage

@@ hdl/mtd_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface mtd_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/mtd_front.sv @@
// Front end: accepts events, drops ignored ones, queues classified commands.
// Depends on mtd_pkg.
`timescale 1ns / 1ps
module mtd_front
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_req_type,
    input  logic [15:0] i_event_code,
    input  logic [31:0] i_event_value,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);
    // two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_keep;
    t_op        n_op;
    logic       w_push, w_pop;

    always_comb begin
        n_keep = 1'b1;
        n_op   = OP_FULL;
        if (i_req_type == EVT_ABS) begin
            unique case (i_event_code)
                AXIS_SLOT:  n_op = OP_SLOT;
                AXIS_TRACK: n_op = OP_TRACK;
                AXIS_X:     n_op = OP_X;
                AXIS_Y:     n_op = OP_Y;
                default:    n_keep = 1'b0;
            endcase
        end else if (i_req_type == EVT_SYNC) begin
            unique case (i_event_code)
                SYNC_FULL:    n_op = OP_FULL;
                SYNC_CONTACT: n_op = OP_CONTACT;
                default:      n_keep = 1'b0;
            endcase
        end else begin
            n_keep = 1'b0;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready && n_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].op    <= n_op;
            r_q[r_wp].value <= i_event_value;
        end
    end

    `include "multitouch_event_decoder_top_assert.svh"
    `MTD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !w_push)
    `MTD_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, r_cnt == 2'd0, !w_pop)
    `MTD_ASSERT_NXT(a_cnt_grows, i_clk, i_rst_n, w_push && !w_pop, r_cnt != 2'd0)
endmodule

@@ hdl/mtd_div.sv @@
// Restoring divider: floor((num << FB) / den), saturated; one bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module mtd_div #(
    parameter int FB = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,  // nonnegative
    input  logic [32:0] i_den,  // positive
    output logic        o_done,
    output logic [15:0] o_q
);
    localparam int QW = 32 + FB;
    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] TOP = (FB >= 16) ? QW'(16'hFFFF) : QW'((1 << FB) - 1);
    logic [QW-1:0] r_n, r_q;
    logic [33:0]   r_rem;
    logic [32:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [33:0]   w_sh;

    assign w_sh = {r_rem[32:0], r_n[QW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(QW - 1)) begin
                r_busy <= 1'b0; r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= {i_num, FB'(0)};
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_n   <= r_n << 1;
            r_cnt <= r_cnt + CW'(1);
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = (r_q > TOP) ? TOP[15:0] : r_q[15:0];
endmodule

@@ hdl/mtd_back.sv @@
// Back end: applies commands to slot/frame state and emits reports.
// Depends on mtd_pkg and mtd_div.
`timescale 1ns / 1ps
module mtd_back
    import mtd_pkg::*;
#(
    parameter int SLOTS = 10,
    parameter int MAXP  = 10,
    parameter int FB    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_xmin,
    input  logic [31:0] i_xmax,
    input  logic [31:0] i_ymin,
    input  logic [31:0] i_ymax,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_point_valid,
    output logic [15:0] o_x_fraction,
    output logic [15:0] o_y_fraction,
    output logic [3:0]  o_point_count,
    output logic        o_last_point
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);

    t_state r_st, n_st;
    logic              r_mode;
    logic [SW-1:0]     r_cur;
    logic [SLOTS-1:0]  r_act;
    logic [31:0]       r_sx [SLOTS];
    logic [31:0]       r_sy [SLOTS];
    logic [31:0]       r_fx [SLOTS];
    logic [31:0]       r_fy [SLOTS];
    logic [31:0]       r_px, r_py;
    logic              r_pv;
    logic [FW-1:0]     r_fill;
    logic [SW-1:0]     r_idx;     // scan position
    logic [3:0]        r_n, r_k;  // count, emitted
    logic [31:0]       r_cx, r_cy;
    logic [15:0]       r_ox, r_oy;
    logic              r_ovalid, r_olast, r_opv;
    logic [3:0]        r_ocnt;
    logic              w_dx, w_dy, r_gx, r_gy, r_start;
    logic [15:0]       w_qx, w_qy;
    logic signed [32:0] w_numx, w_numy;
    // range needs 34 bits: a full 32-bit span plus one reaches 2^32
    logic signed [33:0] w_denx, w_deny;
    logic              w_cmd_take, w_pick, w_scan_end, w_out_free;
    logic [SW-1:0]     w_vs;
    logic [3:0]        n_cnt;

    // active-slot count capped at MAXP (small popcount over the SLOTS activity bits)
    always_comb begin
        n_cnt = '0;
        for (int i = 0; i < SLOTS; i++)
            if (r_act[i] && n_cnt < 4'(MAXP)) n_cnt = n_cnt + 4'd1;
    end

    assign w_out_free = !r_ovalid || i_ready;
    assign w_cmd_take = (r_st == ST_IDLE) && i_cmd_valid;
    assign o_cmd_ready = (r_st == ST_IDLE);
    assign w_pick = r_mode ? r_act[r_idx] : 1'b1;
    assign w_scan_end = (r_k == r_n);

    assign w_numx = $signed({r_cx[31], r_cx}) - $signed({i_xmin[31], i_xmin});
    assign w_numy = $signed({r_cy[31], r_cy}) - $signed({i_ymin[31], i_ymin});
    assign w_denx = $signed({{2{i_xmax[31]}}, i_xmax}) - $signed({{2{i_xmin[31]}}, i_xmin})
                  + 34'sd1;
    assign w_deny = $signed({{2{i_ymax[31]}}, i_ymax}) - $signed({{2{i_ymin[31]}}, i_ymin})
                  + 34'sd1;

    mtd_div #(.FB(FB)) u_divx (.i_clk, .i_rst_n, .i_start(r_start), .i_num(w_numx[31:0]),
        .i_den(w_denx[32:0]), .o_done(w_dx), .o_q(w_qx));
    mtd_div #(.FB(FB)) u_divy (.i_clk, .i_rst_n, .i_start(r_start), .i_num(w_numy[31:0]),
        .i_den(w_deny[32:0]), .o_done(w_dy), .o_q(w_qy));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (w_cmd_take && i_cmd.op == OP_FULL)
                          n_st = (r_mode ? (n_cnt == 4'd0) : (r_fill == '0)) ? ST_EMPTY : ST_SCAN;
            ST_SCAN:  if (w_scan_end) n_st = ST_IDLE;
                      else if (w_pick) n_st = ST_DIV;
            ST_DIV:   if (w_dx) n_st = ST_OUT;
            ST_OUT:   if (w_out_free) n_st = ST_SCAN;
            ST_EMPTY: if (w_out_free) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    assign w_vs = (i_cmd.value[31] || i_cmd.value >= 32'(SLOTS)) ? '0 : i_cmd.value[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_mode <= 1'b0; r_cur <= '0; r_act <= '0;
            r_pv <= 1'b0; r_fill <= '0; r_ovalid <= 1'b0; r_start <= 1'b0;
            r_px <= '0; r_py <= '0;
            for (int i = 0; i < SLOTS; i++) begin r_sx[i] <= '0; r_sy[i] <= '0; end
        end else begin
            r_st <= n_st;
            r_start <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (w_cmd_take) begin
                case (i_cmd.op)
                    OP_SLOT: begin r_mode <= 1'b1; r_cur <= w_vs; end
                    OP_TRACK: if (r_mode) r_act[r_cur] <= !i_cmd.value[31];
                    OP_X: if (r_mode) r_sx[r_cur] <= i_cmd.value;
                          else begin r_px <= i_cmd.value; r_pv <= 1'b1; end
                    OP_Y: if (r_mode) r_sy[r_cur] <= i_cmd.value;
                          else begin r_py <= i_cmd.value; r_pv <= 1'b1; end
                    OP_CONTACT: begin
                        if (r_pv && r_fill < FW'(SLOTS)) r_fill <= r_fill + FW'(1);
                        r_pv <= 1'b0;
                    end
                    OP_FULL: begin
                        r_pv <= 1'b0;
                        r_n  <= r_mode ? n_cnt : ((r_fill > FW'(MAXP)) ? 4'(MAXP) : 4'(r_fill));
                        r_k  <= '0; r_idx <= '0;
                    end
                    default: ;
                endcase
            end
            if (r_st == ST_SCAN && !w_scan_end) begin
                if (w_pick) begin
                    r_cx <= r_mode ? r_sx[r_idx] : r_fx[r_idx];
                    r_cy <= r_mode ? r_sy[r_idx] : r_fy[r_idx];
                    r_gx <= 1'b0; r_gy <= 1'b0;
                    r_start <= 1'b1;
                end
                r_idx <= r_idx + SW'(1);
            end else if (r_st == ST_SCAN) begin
                if (!r_mode) r_fill <= '0;
            end
            if (r_st == ST_IDLE && n_st == ST_EMPTY) r_fill <= '0;
            if (r_st == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1; r_opv <= 1'b1; r_ox <= r_gx ? 16'd0 : w_qx;
                r_oy <= r_gy ? 16'd0 : w_qy; r_ocnt <= r_n;
                r_olast <= (r_k == r_n - 4'd1); r_k <= r_k + 4'd1;
            end
            if (r_st == ST_EMPTY && w_out_free) begin
                r_ovalid <= 1'b1; r_opv <= 1'b0; r_ox <= '0; r_oy <= '0;
                r_ocnt <= '0; r_olast <= 1'b1;
            end
            // zero-force flags: negative numerator or nonpositive range
            if (r_st == ST_DIV && r_start) begin
                r_gx <= w_numx[32] || w_denx[33] || (w_denx == '0);
                r_gy <= w_numy[32] || w_deny[33] || (w_deny == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd_take && i_cmd.op == OP_CONTACT && r_pv && r_fill < FW'(SLOTS)) begin
            r_fx[r_fill[SW-1:0]] <= r_px;
            r_fy[r_fill[SW-1:0]] <= r_py;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_point_valid = r_opv;
    assign o_x_fraction  = r_ox;
    assign o_y_fraction  = r_oy;
    assign o_point_count = r_ocnt;
    assign o_last_point  = r_olast;

    `include "multitouch_event_decoder_top_assert.svh"
    `MTD_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_cmd_ready, r_st == ST_IDLE)
    `MTD_ASSERT_IMP(a_div_pair, i_clk, i_rst_n, w_dx, w_dy)
    `MTD_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_ovalid && !i_ready,
        r_ovalid && $stable(r_ox))
endmodule

@@ hdl/multitouch_event_decoder_top.sv @@
// Top level of the multitouch event decoder: channels, APB registers, front and back.
// Depends on mtd_pkg, mtd_if, mtd_front, mtd_back.
`timescale 1ns / 1ps
// Decodes multitouch events (type/code/value) into reports of normalized contacts. Events are
// queued two deep by the front end and applied by the back end while it is idle; a full sync
// walks the slots (or frame entries) one per cycle, pausing at each contact to normalize
// and report it using a one-bit-per-cycle divider. Range registers sit at byte 0,4,8,12
// (x min, x max, y min, y max) and must be written only while the block is idle.
module multitouch_event_decoder_top
    import mtd_pkg::*;
#(
    parameter int SLOT_COUNT    = 10,
    parameter int MAX_POINTS    = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtd_if.sink         in_ch,
    mtd_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic        w_cv, w_cr;
    t_cmd        w_cmd;
    logic        w_pv, w_lp;
    logic [15:0] w_xf, w_yf;
    logic [3:0]  w_pc;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= 32'd0; r_xmax <= 32'd4095; r_ymin <= 32'd0; r_ymax <= 32'd4095;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_XMIN: r_xmin <= pwdata;
                REG_XMAX: r_xmax <= pwdata;
                REG_YMIN: r_ymin <= pwdata;
                REG_YMAX: r_ymax <= pwdata;
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            REG_XMIN: prdata = r_xmin;
            REG_XMAX: prdata = r_xmax;
            REG_YMIN: prdata = r_ymin;
            REG_YMAX: prdata = r_ymax;
            default:  prdata = '0;
        endcase
    end

    mtd_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_req_type(in_ch.data[63:48]), .i_event_code(in_ch.data[47:32]),
        .i_event_value(in_ch.data[31:0]),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    mtd_back #(.SLOTS(SLOT_COUNT), .MAXP(MAX_POINTS), .FB(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .i_xmin(r_xmin), .i_xmax(r_xmax), .i_ymin(r_ymin), .i_ymax(r_ymax),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_point_valid(w_pv), .o_x_fraction(w_xf), .o_y_fraction(w_yf),
        .o_point_count(w_pc), .o_last_point(w_lp)
    );

    assign out_ch.data = {w_pv, w_xf, w_yf, w_pc, w_lp};
endmodule
